### design/gadc_pkg.sv
// gadc_pkg: shared types and constants of the gamepad axis to drive command block
// used by the channel interfaces and the top level; no dependencies

package gadc_pkg;

	// field widths
	localparam int CODE_W  = 6;
	localparam int VAL_W   = 16;
	localparam int DB_W    = 16;
	localparam int STEER_W = 16;
	localparam int PED_W   = 15;

	// fixed point format of the normalized value, 1.0 = 2^FRAC_BITS
	localparam int FRAC_BITS = 15;

	// |n| is at most 1.0
	localparam int MAG_W = FRAC_BITS + 1;
	// quotient register, holds up to 2.0 plus headroom
	localparam int QUO_W = FRAC_BITS + 2;
	// dividend 2*|num|*2^F + |span|, with |num| < 2^17 and |span| < 2^16
	localparam int DVD_W = FRAC_BITS + 19;
	// divisor 2*|span|
	localparam int DVS_W = 17;
	localparam int CNT_W = $clog2(DVD_W + 1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_STEER_CODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_CODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 3'd6;

	typedef logic [CODE_W-1:0]        code_t;
	typedef logic signed [VAL_W-1:0]  raw_t;
	typedef logic [DB_W-1:0]          band_t;
	typedef logic signed [STEER_W-1:0] steer_t;
	typedef logic [PED_W-1:0]         pedal_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	// register reset values
	localparam code_t RST_STEER_CODE = 6'd0;
	localparam code_t RST_PEDAL_CODE = 6'd4;
	localparam raw_t  RST_AXIS_MIN   = -16'sd24576;
	localparam raw_t  RST_AXIS_MAX   = 16'sd24575;
	localparam band_t RST_DEAD_BAND  = 16'd0;

endpackage

### design/gadc_evt_if.sv
// gadc_evt_if: valid/ready channel carrying one axis event
// depends on gadc_pkg for the field types

interface gadc_evt_if;
	logic             valid;
	logic             ready;
	gadc_pkg::code_t  ev_code;
	gadc_pkg::raw_t   axis_value;

	modport source (output valid, output ev_code, output axis_value, input ready);
	modport sink   (input valid, input ev_code, input axis_value, output ready);
endinterface

### design/gadc_cmd_if.sv
// gadc_cmd_if: valid/ready channel carrying one drive command set
// depends on gadc_pkg for the field types

interface gadc_cmd_if;
	logic             valid;
	logic             ready;
	gadc_pkg::steer_t steer_cmd;
	gadc_pkg::pedal_t throttle_cmd;
	gadc_pkg::pedal_t brake_cmd;

	modport source (output valid, output steer_cmd, output throttle_cmd, output brake_cmd,
		input ready);
	modport sink   (input valid, input steer_cmd, input throttle_cmd, input brake_cmd,
		output ready);
endinterface

### design/gamepad_axis_to_drive_command_top.sv
// gamepad_axis_to_drive_command_top: axis event to steering/throttle/brake command
// depends on gadc_pkg, gadc_evt_if and gadc_cmd_if
//
// Usage
//   evt: one axis event per transfer (ev_code, axis_value). Events whose code
//     matches neither the steering nor the pedal code are taken and dropped.
//   cmd: one transfer per matching event, carrying the whole held command set.
//   cfg: write cfg_data into register cfg_idx when cfg_we is high; only while idle.
// Timing
//   The raw value is normalized by a restoring divider that produces one quotient
//   bit per cycle over all DVD_W dividend bits (FRAC_BITS = 15, Q1.15). A steering
//   event then takes a normalize step and the square and cube on a shared
//   multiplier; a pedal event skips the multiplier. One event is in work at a
//   time, so the next event is taken only once the last one has written its
//   command.
// Stalls
//   The held command registers drive cmd directly. A finished result waits in
//   them while cmd is stalled; the next event is accepted and computed meanwhile
//   and only its final write waits for the transfer.
// Reset
//   arst_n clears the held commands to zero, drops cmd.valid and loads the
//   register defaults; evt.ready is high right after reset.

module gamepad_axis_to_drive_command_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  gadc_pkg::cfg_idx_t   cfg_idx,
	input  gadc_pkg::cfg_data_t  cfg_data,
	gadc_evt_if.sink             evt,
	gadc_cmd_if.source           cmd
);
	import gadc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_NORM = 3'd2;
	localparam logic [2:0] S_SQ   = 3'd3;
	localparam logic [2:0] S_CUBE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	localparam logic [QUO_W-1:0] ONE_Q  = QUO_W'(1) << FRAC_BITS;
	localparam logic [QUO_W-1:0] TWO_Q  = QUO_W'(2) << FRAC_BITS;
	localparam logic [MAG_W-1:0] ONE_M  = MAG_W'(1) << FRAC_BITS;
	localparam int               PROD_W = 2 * MAG_W;
	localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);
	localparam int CMP_W = (MAG_W > DB_W) ? MAG_W : DB_W;
	localparam int SAT_W = (MAG_W > PED_W + 1) ? MAG_W : PED_W + 1;
	localparam int ST_W  = (MAG_W > STEER_W + 1) ? MAG_W : STEER_W + 1;
	localparam logic [SAT_W-1:0] PED_CAP = SAT_W'((1 << PED_W) - 1);
	localparam logic [ST_W-1:0]  POS_CAP = ST_W'((1 << (STEER_W - 1)) - 1);
	localparam logic [ST_W-1:0]  NEG_CAP = ST_W'(1 << (STEER_W - 1));

	// configuration registers
	code_t steer_code_q, pedal_code_q;
	raw_t  steer_min_q, steer_max_q, pedal_min_q, pedal_max_q;
	band_t dead_band_q;

	// control state
	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             is_steer_q;
	logic             zero_q;
	logic             neg_q;
	logic             ovf_q;
	logic             cmd_valid_q;

	// datapath registers
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [MAG_W-1:0] mag_q;
	logic             sgn_q;
	logic [MAG_W-1:0] pow_q;
	steer_t           held_steer_q;
	pedal_t           held_throttle_q;
	pedal_t           held_brake_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_code_q <= RST_STEER_CODE;
			pedal_code_q <= RST_PEDAL_CODE;
			steer_min_q  <= RST_AXIS_MIN;
			steer_max_q  <= RST_AXIS_MAX;
			pedal_min_q  <= RST_AXIS_MIN;
			pedal_max_q  <= RST_AXIS_MAX;
			dead_band_q  <= RST_DEAD_BAND;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_STEER_CODE: steer_code_q <= cfg_data[CODE_W-1:0];
				CFG_PEDAL_CODE: pedal_code_q <= cfg_data[CODE_W-1:0];
				CFG_STEER_MIN:  steer_min_q  <= raw_t'(cfg_data);
				CFG_STEER_MAX:  steer_max_q  <= raw_t'(cfg_data);
				CFG_PEDAL_MIN:  pedal_min_q  <= raw_t'(cfg_data);
				CFG_PEDAL_MAX:  pedal_max_q  <= raw_t'(cfg_data);
				CFG_DEAD_BAND:  dead_band_q  <= band_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// event decode and divider operands
	logic                  evt_acc, cmd_acc;
	logic                  hit_steer, hit_pedal;
	raw_t                  lo_sel, hi_sel;
	logic signed [16:0]    lo_x, hi_x, val_x, diff, span;
	logic signed [17:0]    num;
	logic [17:0]           num_neg;
	logic [16:0]           span_neg;
	logic [16:0]           num_mag;
	logic [15:0]           span_mag;
	logic [DVD_W-1:0]      dvd_init;

	assign evt.ready = (state_q == S_IDLE);
	assign evt_acc   = evt.valid && evt.ready;
	assign cmd_acc   = cmd_valid_q && cmd.ready;

	assign hit_steer = (evt.ev_code == steer_code_q);
	assign hit_pedal = !hit_steer && (evt.ev_code == pedal_code_q);
	assign lo_sel    = hit_steer ? steer_min_q : pedal_min_q;
	assign hi_sel    = hit_steer ? steer_max_q : pedal_max_q;
	assign lo_x      = 17'(lo_sel);
	assign hi_x      = 17'(hi_sel);
	assign val_x     = 17'(evt.axis_value);
	assign diff      = val_x - lo_x;
	assign span      = hi_x - lo_x;
	assign num       = {diff, 1'b0};
	assign num_neg   = 18'(-num);
	assign span_neg  = 17'(-span);
	assign num_mag   = num[17] ? num_neg[16:0] : num[16:0];
	assign span_mag  = span[16] ? span_neg[15:0] : span[15:0];
	assign dvd_init  = (DVD_W'(num_mag) << (FRAC_BITS + 1)) + DVD_W'(span_mag);

	// one restoring division step
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             quo_bit;

	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign quo_bit = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// normalize: n = q - 1.0, clamped, then deadzone
	logic [QUO_W-1:0] q_lo, q_hi;
	logic [MAG_W-1:0] nrm_mag;
	logic             nrm_sgn;

	assign q_lo = ONE_Q - quo_q;
	assign q_hi = quo_q - ONE_Q;

	always_comb begin
		if (zero_q) begin
			nrm_mag = '0;
			nrm_sgn = 1'b0;
		end else if (neg_q) begin
			nrm_mag = ONE_M;
			nrm_sgn = 1'b1;
		end else if (ovf_q || (quo_q >= TWO_Q)) begin
			nrm_mag = ONE_M;
			nrm_sgn = 1'b0;
		end else if (quo_q < ONE_Q) begin
			nrm_mag = q_lo[MAG_W-1:0];
			nrm_sgn = 1'b1;
		end else begin
			nrm_mag = q_hi[MAG_W-1:0];
			nrm_sgn = 1'b0;
		end
		if (CMP_W'(nrm_mag) < CMP_W'(dead_band_q)) begin
			nrm_mag = '0;
			nrm_sgn = 1'b0;
		end
	end

	// shared multiplier for |n|^2 and |n|^3, rounded back to the fixed-point format
	logic [MAG_W-1:0]  mul_a;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_rnd;

	assign mul_a    = (state_q == S_SQ) ? mag_q : pow_q;
	assign prod     = PROD_W'(mul_a) * PROD_W'(mag_q);
	assign prod_rnd = (prod + HALF_P) >> FRAC_BITS;

	// saturate to the output fields
	logic [ST_W-1:0]    pow_x;
	logic [SAT_W-1:0]   mag_x;
	logic [STEER_W-1:0] pow_t, pow_neg;
	steer_t             steer_next;
	pedal_t             ped_sat;

	assign pow_x   = ST_W'(pow_q);
	assign mag_x   = SAT_W'(mag_q);
	assign pow_t   = pow_x[STEER_W-1:0];
	assign pow_neg = STEER_W'(~pow_t + 1'b1);
	assign ped_sat = (mag_x > PED_CAP) ? PED_CAP[PED_W-1:0] : mag_x[PED_W-1:0];

	always_comb begin
		if (sgn_q) begin
			steer_next = (pow_x > NEG_CAP) ? steer_t'(NEG_CAP[STEER_W-1:0]) : steer_t'(pow_neg);
		end else begin
			steer_next = (pow_x > POS_CAP) ? steer_t'(POS_CAP[STEER_W-1:0]) : steer_t'(pow_t);
		end
	end

	logic out_free;
	assign out_free = !cmd_valid_q || cmd.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			is_steer_q <= 1'b0;
			zero_q     <= 1'b0;
			neg_q      <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (evt_acc && (hit_steer || hit_pedal)) begin
						state_q    <= S_DIV;
						cnt_q      <= CNT_W'(DVD_W);
						is_steer_q <= hit_steer;
						zero_q     <= (span == '0);
						neg_q      <= num[17] ^ span[16];
						ovf_q      <= 1'b0;
					end
				end
				S_DIV: begin
					ovf_q <= ovf_q | quo_q[QUO_W-1];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					state_q <= is_steer_q ? S_SQ : S_DONE;
				end
				S_SQ: begin
					state_q <= S_CUBE;
				end
				S_CUBE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// divider and multiplier datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dvd_q <= dvd_init;
				dvs_q <= {span_mag, 1'b0};
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				dvd_q <= dvd_q << 1;
				rem_q <= quo_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], quo_bit};
			end
			S_NORM: begin
				mag_q <= nrm_mag;
				sgn_q <= nrm_sgn;
			end
			S_SQ, S_CUBE: begin
				pow_q <= prod_rnd[MAG_W-1:0];
			end
			default: ;
		endcase
	end

	// held commands double as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_steer_q    <= '0;
			held_throttle_q <= '0;
			held_brake_q    <= '0;
			cmd_valid_q     <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				cmd_valid_q <= 1'b1;
				if (is_steer_q) begin
					held_steer_q <= steer_next;
				end else begin
					held_throttle_q <= sgn_q ? ped_sat : '0;
					held_brake_q    <= sgn_q ? '0 : ped_sat;
				end
			end else if (cmd_acc) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	assign cmd.valid        = cmd_valid_q;
	assign cmd.steer_cmd    = held_steer_q;
	assign cmd.throttle_cmd = held_throttle_q;
	assign cmd.brake_cmd    = held_brake_q;

`ifndef SYNTHESIS
	// a stalled result keeps its payload
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_q && !cmd.ready |=> $stable(held_steer_q) && $stable(held_throttle_q)
			&& $stable(held_brake_q))
		else $error("held command changed while the output was stalled");

	// the divider always hands over to normalization after its last step
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == CNT_W'(1) |=> state_q == S_NORM)
		else $error("divider did not finish on its last step");

	// only steering events use the multiplier
	a_mul_steer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ || state_q == S_CUBE) |-> is_steer_q)
		else $error("pedal event entered the cube stage");

	// normalized magnitude never exceeds one
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQ |-> mag_q <= ONE_M)
		else $error("normalized magnitude above one");

	// throttle and brake are never applied together
	a_pedal_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(held_throttle_q != '0 && held_brake_q != '0))
		else $error("throttle and brake both nonzero");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for gamepad_axis_to_drive_command_top
// drives axis events and register writes, predicts each drive command set in
// place; depends on gadc_pkg, gadc_evt_if, gadc_cmd_if and the top level

module testbench;
	import gadc_pkg::*;

	localparam longint ONE            = longint'(1) << FRAC_BITS;
	localparam longint STEER_TOP      = (longint'(1) << (STEER_W - 1)) - 1;
	localparam longint PEDAL_TOP      = (longint'(1) << PED_W) - 1;
	localparam cfg_idx_t CFG_UNUSED   = 3'd7;
	localparam int PER_PHASE          = 96;
	localparam int NPHASE             = 12;
	localparam int NFIXED             = 7;
	localparam int NPROBE             = 22;
	localparam int SETTLE_CYCLES      = 60;
	localparam int LONG_HOLD          = 400;
	localparam int unsigned TIMEOUT_CYCLES = 500000;

	typedef struct packed {
		steer_t steer;
		pedal_t throttle;
		pedal_t brake;
	} drive_cmd_t;

	typedef struct packed {
		code_t      code;
		raw_t       value;
		bit         typed;
		drive_cmd_t result;
	} probe_t;

	typedef struct packed {
		code_t steer_code;
		code_t pedal_code;
		raw_t  steer_lo;
		raw_t  steer_hi;
		raw_t  pedal_lo;
		raw_t  pedal_hi;
		band_t band;
	} axis_setting_t;

	// directed events under the reset settings; typed results only at the extremes
	localparam probe_t PROBES [NPROBE] = '{
		'{6'd0,  -16'sd24576, 1'b1, '{16'h8000, 15'd0, 15'd0}},
		'{6'd0,  16'sd24575,  1'b1, '{16'sd32767, 15'd0, 15'd0}},
		'{6'd0,  16'sd32767,  1'b1, '{16'sd32767, 15'd0, 15'd0}},
		'{6'd0,  16'h8000,    1'b1, '{16'h8000, 15'd0, 15'd0}},
		'{6'd4,  -16'sd24576, 1'b1, '{16'h8000, 15'd32767, 15'd0}},
		'{6'd4,  16'sd24575,  1'b1, '{16'h8000, 15'd0, 15'd32767}},
		'{6'd4,  16'sd32767,  1'b1, '{16'h8000, 15'd0, 15'd32767}},
		'{6'd4,  16'h8000,    1'b1, '{16'h8000, 15'd32767, 15'd0}},
		'{6'd5,  16'sd0,      1'b0, '0},
		'{6'd63, -16'sd1,     1'b0, '0},
		'{6'd42, 16'sh5555,   1'b0, '0},
		'{6'd21, 16'shAAAA,   1'b0, '0},
		'{6'd0,  16'sd0,      1'b0, '0},
		'{6'd0,  -16'sd1,     1'b0, '0},
		'{6'd0,  16'sd12288,  1'b0, '0},
		'{6'd0,  -16'sd12288, 1'b0, '0},
		'{6'd4,  16'sd0,      1'b0, '0},
		'{6'd4,  -16'sd1,     1'b0, '0},
		'{6'd4,  16'sd12288,  1'b0, '0},
		'{6'd4,  -16'sd12289, 1'b0, '0},
		'{6'd0,  16'sd21845,  1'b0, '0},
		'{6'd4,  -16'sd21846, 1'b0, '0}
	};

	// settings of the first phases: reset values, full range, inverted range,
	// shared code with flat range, tiny pedal span, flat pedal, dead band above one
	localparam axis_setting_t FIXED_SETTINGS [NFIXED] = '{
		'{6'd0,  6'd4,  -16'sd24576, 16'sd24575, -16'sd24576, 16'sd24575, 16'd0},
		'{6'd63, 6'd62, 16'h8000, 16'sd32767, 16'h8000, 16'sd32767, 16'd0},
		'{6'd62, 6'd63, 16'sd32767, 16'h8000, 16'sd32767, 16'h8000, 16'd32768},
		'{6'd10, 6'd10, 16'sd100, 16'sd100, -16'sd5, -16'sd5, 16'd0},
		'{6'd21, 6'd42, 16'sd1000, -16'sd1000, 16'sd0, 16'sd1, 16'd2000},
		'{6'd1,  6'd2,  -16'sd100, 16'sd100, 16'sd4000, 16'sd4000, 16'd16384},
		'{6'd5,  6'd6,  16'sd0, 16'sd32767, 16'h8000, 16'sd0, 16'hFFFF}
	};

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_idx;
	cfg_data_t cfg_data;

	gadc_evt_if evt_ch ();
	gadc_cmd_if cmd_ch ();

	gamepad_axis_to_drive_command_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.evt      (evt_ch),
		.cmd      (cmd_ch)
	);

	// predictor copy of the registers and the held command set
	code_t steer_code_q = RST_STEER_CODE;
	code_t pedal_code_q = RST_PEDAL_CODE;
	raw_t  steer_lo_q   = RST_AXIS_MIN;
	raw_t  steer_hi_q   = RST_AXIS_MAX;
	raw_t  pedal_lo_q   = RST_AXIS_MIN;
	raw_t  pedal_hi_q   = RST_AXIS_MAX;
	band_t dead_band_q  = RST_DEAD_BAND;
	drive_cmd_t held_cmd = '0;

	drive_cmd_t cmd_pending [$];
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;
	bit          long_hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// normalized axis position, rounded on magnitudes, clamped, dead band applied
	function automatic longint scale_axis(raw_t value, raw_t lo, raw_t hi);
		longint span, num, a, b, q, n;
		bit neg;
		span = longint'(hi) - longint'(lo);
		if (span == 0)
			return 0;
		num = 2 * (longint'(value) - longint'(lo));
		neg = (num < 0) != (span < 0);
		a = (num < 0 ? -num : num) << FRAC_BITS;
		b = span < 0 ? -span : span;
		q = (2 * a + b) / (2 * b);
		n = (neg ? -q : q) - ONE;
		if (n < -ONE)
			n = -ONE;
		if (n > ONE)
			n = ONE;
		if ((n < 0 ? -n : n) < longint'(dead_band_q))
			n = 0;
		return n;
	endfunction

	// sign(n) * |n|^3 with rounding after each product
	function automatic longint cube_curve(longint n);
		longint a, a2, a3;
		a  = n < 0 ? -n : n;
		a2 = (a * a + ONE / 2) >> FRAC_BITS;
		a3 = (a2 * a + ONE / 2) >> FRAC_BITS;
		return n < 0 ? -a3 : a3;
	endfunction

	function automatic pedal_t pedal_pin(longint v);
		if (v < 0)
			return '0;
		if (v > PEDAL_TOP)
			return pedal_t'(PEDAL_TOP);
		return pedal_t'(v);
	endfunction

	// advance the held command set for one accepted event
	task automatic update_drive_cmd(code_t code, raw_t value, output bit hit);
		longint n;
		hit = 1'b1;
		if (code == steer_code_q) begin
			n = cube_curve(scale_axis(value, steer_lo_q, steer_hi_q));
			held_cmd.steer = steer_t'(n > STEER_TOP ? STEER_TOP : n);
		end else if (code == pedal_code_q) begin
			n = scale_axis(value, pedal_lo_q, pedal_hi_q);
			held_cmd.throttle = pedal_pin(-n);
			held_cmd.brake    = pedal_pin(n);
		end else begin
			hit = 1'b0;
		end
	endtask

	// offer one event and wait for its transfer; valid stays high on return
	task automatic push_event(code_t code, raw_t value, bit typed, drive_cmd_t typed_cmd);
		bit hit;
		evt_ch.valid      <= 1'b1;
		evt_ch.ev_code    <= code;
		evt_ch.axis_value <= value;
		do
			@(posedge clk);
		while (evt_ch.ready !== 1'b1);
		update_drive_cmd(code, value, hit);
		if (hit)
			cmd_pending.push_back(typed ? typed_cmd : held_cmd);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_STEER_CODE: steer_code_q = code_t'(data);
			CFG_PEDAL_CODE: pedal_code_q = code_t'(data);
			CFG_STEER_MIN:  steer_lo_q   = raw_t'(data);
			CFG_STEER_MAX:  steer_hi_q   = raw_t'(data);
			CFG_PEDAL_MIN:  pedal_lo_q   = raw_t'(data);
			CFG_PEDAL_MAX:  pedal_hi_q   = raw_t'(data);
			CFG_DEAD_BAND:  dead_band_q  = band_t'(data);
			default: ;
		endcase
	endtask

	task automatic load_setting(axis_setting_t s);
		write_reg(CFG_STEER_CODE, cfg_data_t'(s.steer_code));
		write_reg(CFG_PEDAL_CODE, cfg_data_t'(s.pedal_code));
		write_reg(CFG_STEER_MIN, cfg_data_t'(s.steer_lo));
		write_reg(CFG_STEER_MAX, cfg_data_t'(s.steer_hi));
		write_reg(CFG_PEDAL_MIN, cfg_data_t'(s.pedal_lo));
		write_reg(CFG_PEDAL_MAX, cfg_data_t'(s.pedal_hi));
		write_reg(CFG_DEAD_BAND, cfg_data_t'(s.band));
		// index past the register list, must change nothing
		write_reg(CFG_UNUSED, cfg_data_t'($urandom));
		cfg_we <= 1'b0;
	endtask

	// wait for every expected command, then for the block to go quiet
	task automatic drain_and_idle();
		evt_ch.valid <= 1'b0;
		while (cmd_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic axis_setting_t random_setting();
		axis_setting_t s;
		s.steer_code = code_t'($urandom_range(0, 63));
		s.pedal_code = ($urandom_range(0, 3) == 0) ? s.steer_code
			: code_t'($urandom_range(0, 63));
		s.steer_lo = raw_t'($urandom_range(0, 65535));
		s.steer_hi = $urandom_range(0, 1) ? raw_t'(s.steer_lo + $urandom_range(0, 64))
			: raw_t'($urandom_range(0, 65535));
		s.pedal_lo = raw_t'($urandom_range(0, 65535));
		s.pedal_hi = $urandom_range(0, 1) ? raw_t'(s.pedal_lo + $urandom_range(0, 64))
			: raw_t'($urandom_range(0, 65535));
		s.band = ($urandom_range(0, 4) == 0) ? band_t'($urandom_range(0, 32769))
			: band_t'($urandom_range(0, 3000));
		return s;
	endfunction

	// raw value: mostly inside the axis range, some at its edges, some anywhere
	function automatic raw_t pick_value(raw_t lo, raw_t hi);
		int a, b;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		case ($urandom_range(0, 9))
			0, 1: return raw_t'($urandom_range(0, 65535));
			2: begin
				case ($urandom_range(0, 3))
					0: return raw_t'(a);
					1: return raw_t'(b);
					2: return raw_t'(a - 1);
					default: return raw_t'(b + 1);
				endcase
			end
			default: return raw_t'(a + int'($urandom_range(0, b - a)));
		endcase
	endfunction

	// command sink: random stalls, one long hold-off on request
	initial begin : cmd_sink
		bit hold_done;
		hold_done = 1'b0;
		cmd_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				cmd_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				cmd_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				cmd_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				cmd_ch.ready <= 1'b1;
			end else begin
				cmd_ch.ready <= 1'b1;
			end
		end
	end

	// compare each command transfer with the oldest expectation
	always @(posedge clk) begin : cmd_check
		drive_cmd_t want;
		if (arst_n === 1'b1 && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
			if (cmd_pending.size() == 0) begin
				$display("%0t: unexpected command transfer, steer %0d throttle %0d brake %0d",
					$time, cmd_ch.steer_cmd, cmd_ch.throttle_cmd, cmd_ch.brake_cmd);
				mismatches++;
			end else begin
				want = cmd_pending.pop_front();
				if (cmd_ch.steer_cmd !== want.steer) begin
					$display("%0t: steer_cmd expected %0d, got %0d",
						$time, want.steer, cmd_ch.steer_cmd);
					mismatches++;
				end
				if (cmd_ch.throttle_cmd !== want.throttle) begin
					$display("%0t: throttle_cmd expected %0d, got %0d",
						$time, want.throttle, cmd_ch.throttle_cmd);
					mismatches++;
				end
				if (cmd_ch.brake_cmd !== want.brake) begin
					$display("%0t: brake_cmd expected %0d, got %0d",
						$time, want.brake, cmd_ch.brake_cmd);
					mismatches++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("%0t: timeout, %0d commands still expected", $time, cmd_pending.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		axis_setting_t s;
		int unsigned   gap_odds;
		int unsigned   sel;
		code_t         code;
		raw_t          value;
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = '0;
		cfg_data          = '0;
		evt_ch.valid      = 1'b0;
		evt_ch.ev_code    = '0;
		evt_ch.axis_value = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed events under the reset settings
		foreach (PROBES[i])
			push_event(PROBES[i].code, PROBES[i].value, PROBES[i].typed, PROBES[i].result);

		for (int p = 0; p < NPHASE; p++) begin
			if (p > 0) begin
				drain_and_idle();
				s = (p < NFIXED) ? FIXED_SETTINGS[p] : random_setting();
				load_setting(s);
			end
			if (p == 1)
				long_hold_req <= 1'b1;
			if (p == NPHASE - 1)
				quiet <= 1'b1;
			// every third phase and the last one run without source gaps
			gap_odds = (p % 3 == 2 || p == NPHASE - 1) ? 0 : 4;
			for (int i = 0; i < PER_PHASE; i++) begin
				if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
					evt_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 9)) @(posedge clk);
				end
				sel = $urandom_range(0, 9);
				if (sel < 5) begin
					code  = steer_code_q;
					value = pick_value(steer_lo_q, steer_hi_q);
				end else if (sel < 9) begin
					code  = pedal_code_q;
					value = pick_value(pedal_lo_q, pedal_hi_q);
				end else begin
					code  = code_t'($urandom_range(0, 63));
					value = raw_t'($urandom_range(0, 65535));
				end
				push_event(code, value, 1'b0, '0);
			end
		end

		drain_and_idle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
